### hdl/pwr_pkg.sv
package pwr_pkg;

    localparam int unsigned PixelWidth = 32;
    localparam int unsigned OutWidth   = 16;
    localparam int unsigned FracBits   = 16;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic signed [PixelWidth-1:0] TrackMinReset = 32'sh7FFF_FFFF;
    localparam logic signed [PixelWidth-1:0] TrackMaxReset = 32'sh8000_0000;
    localparam logic signed [PixelWidth-1:0] UserMinReset  = 32'sh0000_0000;
    localparam logic signed [PixelWidth-1:0] UserMaxReset  = 32'sh0001_0000;

    localparam logic [OutWidth-1:0] FullNarrow = 16'd255;
    localparam logic [OutWidth-1:0] FullWide   = 16'd65535;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_OUTPUT_WIDE    = 3'd0,
        REG_RESCALE_ENABLE = 3'd1,
        REG_RANGE_GIVEN    = 3'd2,
        REG_USER_MIN       = 3'd3,
        REG_USER_MAX       = 3'd4
    } pwr_reg_idx_t;

    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_CONVERT = 1'b1
    } pwr_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_DIFF,
        ST_LOAD,
        ST_DIVIDE,
        ST_WRITE
    } pwr_state_t;

    typedef struct packed {
        logic                         operation;
        logic signed [PixelWidth-1:0] pixel;
        logic                         last;
    } pwr_in_t;

    typedef struct packed {
        logic [OutWidth-1:0] pixel_out;
        logic                last_out;
    } pwr_out_t;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic                  start;
        logic                  wide;
        logic [PixelWidth-1:0] num;
        logic [PixelWidth-1:0] den;
    } pwr_div_req_t;

endpackage

### hdl/pwr_divider.sv
module pwr_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwr_pkg::pwr_div_req_t req,
    output logic                  done,
    output logic [15:0]           quotient
);
    import pwr_pkg::*;

    // Computes floor(num * full / den), with num <= den so the quotient fits
    // in 16 bits. The product is formed at start by shift and subtract, then
    // a restoring divider produces one quotient bit per cycle.
    localparam int unsigned ProdWidth = PixelWidth + OutWidth;

    logic                  busy_reg, busy_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [PixelWidth-1:0] rem_reg, rem_next;
    logic [OutWidth-1:0]   sh_reg, sh_next;
    logic [PixelWidth-1:0] den_reg, den_next;

    logic [ProdWidth-1:0]  num_ext;
    logic [ProdWidth-1:0]  product;
    logic [PixelWidth:0]   trial;
    logic [PixelWidth:0]   diff;
    logic                  fits;

    always_comb
    begin
        num_ext = {{OutWidth{1'b0}}, req.num};
        product = req.wide ? ((num_ext << 16) - num_ext) : ((num_ext << 8) - num_ext);
        trial   = {rem_reg, sh_reg[OutWidth-1]};
        diff    = trial - {1'b0, den_reg};
        fits    = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = product[ProdWidth-1:OutWidth];
            sh_next   = product[OutWidth-1:0];
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PixelWidth-1:0] : trial[PixelWidth-1:0];
            sh_next  = {sh_reg[OutWidth-2:0], fits};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done     = busy_reg && (cnt_reg == 4'd15);
    assign quotient = sh_reg;

endmodule

### hdl/pixel_window_rescale_to_int.sv
// Pixel window rescaler: signed Q16.16 pixels in, unsigned 8- or 16-bit out.
// The source channel (src_valid, src_stall, src_item) carries measure and
// convert items. A measure item updates the running minimum and maximum in
// the cycle it is accepted and produces no result. A convert item produces
// exactly one result on the destination channel (dst_valid, dst_stall,
// dst_item). The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready and should be written only while the block is idle.
// A measure item leaves the block idle, ready for the next item. A convert
// item with rescale off goes from idle to the write step. With rescale on it
// passes the clip, difference and load steps, the restoring divider that is
// shared by all pixels, and the write step; an empty window skips the divider.
// Every result reaches the output register from the write step.
// The block holds src_stall high while a convert item is in work.
// The result sits in an output register; while the receiver stalls, the block
// still accepts the next item and stalls only if a second result is ready
// before the first is taken. Reset returns the state, output valid and config
// registers to their defaults, the trackers to an inverted full-range window.
// The last convert item of a frame clears the trackers as its result registers.
module pixel_window_rescale_to_int (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  pwr_pkg::pwr_in_t                    src_item,
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output pwr_pkg::pwr_out_t                   dst_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwr_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [pwr_pkg::PixelWidth-1:0]      cfg_data
);
    import pwr_pkg::*;

    pwr_state_t state_reg, state_next;

    // Configuration registers.
    logic                         wide_reg;
    logic                         rescale_reg;
    logic                         given_reg;
    logic signed [PixelWidth-1:0] umin_reg;
    logic signed [PixelWidth-1:0] umax_reg;

    // Frame trackers.
    logic signed [PixelWidth-1:0] tmin_reg, tmin_next;
    logic signed [PixelWidth-1:0] tmax_reg, tmax_next;

    // Item working registers.
    logic signed [PixelWidth-1:0] x_reg, x_next;
    logic signed [PixelWidth-1:0] lo_reg, lo_next;
    logic                         last_reg, last_next;
    logic                         inc_reg, inc_next;
    logic [PixelWidth-1:0]        den_reg, den_next;
    logic [PixelWidth-1:0]        num_reg, num_next;
    logic [OutWidth-1:0]          res_reg, res_next;
    logic                         use_div_reg, use_div_next;

    // Output register.
    logic                         ovalid_reg, ovalid_next;
    pwr_out_t                     odata_reg, odata_next;

    logic                         accept;
    logic [OutWidth-1:0]          full;
    logic [OutWidth-1:0]          trunc_val;
    logic [FracBits-1:0]          int_part;
    logic signed [PixelWidth-1:0] win_lo;
    logic signed [PixelWidth-1:0] win_hi;
    logic signed [PixelWidth-1:0] clip_lo;
    logic signed [PixelWidth-1:0] clip_hi;
    logic                         div_done;
    logic [OutWidth-1:0]          quotient;
    pwr_div_req_t                 div_req;

    assign cfg_ready = 1'b1;
    assign src_stall = (state_reg != ST_IDLE);
    assign accept    = src_valid && !src_stall;
    assign full      = wide_reg ? FullWide : FullNarrow;
    assign dst_valid = ovalid_reg;
    assign dst_item  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg    <= 1'b0;
            rescale_reg <= 1'b0;
            given_reg   <= 1'b0;
            umin_reg    <= UserMinReset;
            umax_reg    <= UserMaxReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OUTPUT_WIDE:    wide_reg    <= cfg_data[0];
                REG_RESCALE_ENABLE: rescale_reg <= cfg_data[0];
                REG_RANGE_GIVEN:    given_reg   <= cfg_data[0];
                REG_USER_MIN:       umin_reg    <= cfg_data;
                REG_USER_MAX:       umax_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Integer part of a pixel, saturated to the full scale; a negative pixel gives zero.
    always_comb
    begin
        int_part = src_item.pixel[PixelWidth-1:FracBits];
        if (src_item.pixel[PixelWidth-1])
        begin
            trunc_val = '0;
        end
        else if (int_part > full)
        begin
            trunc_val = full;
        end
        else
        begin
            trunc_val = int_part;
        end
    end

    assign win_lo = given_reg ? umin_reg : tmin_reg;
    assign win_hi = given_reg ? umax_reg : tmax_reg;

    // The clip interval is the window with its ends in ascending order.
    assign clip_lo = (win_lo < win_hi) ? win_lo : win_hi;
    assign clip_hi = (win_lo < win_hi) ? win_hi : win_lo;

    always_comb
    begin
        state_next   = state_reg;
        tmin_next    = tmin_reg;
        tmax_next    = tmax_reg;
        x_next       = x_reg;
        lo_next      = lo_reg;
        last_next    = last_reg;
        inc_next     = inc_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        res_next     = res_reg;
        use_div_next = use_div_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;

        div_req.start = 1'b0;
        div_req.wide  = wide_reg;
        div_req.num   = num_reg;
        div_req.den   = den_reg;

        if (ovalid_reg && !dst_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next       = src_item.pixel;
                    last_next    = src_item.last;
                    use_div_next = 1'b0;
                    if (src_item.operation == OP_MEASURE)
                    begin
                        if (src_item.pixel < tmin_reg)
                        begin
                            tmin_next = src_item.pixel;
                        end
                        if (src_item.pixel > tmax_reg)
                        begin
                            tmax_next = src_item.pixel;
                        end
                    end
                    else if (rescale_reg)
                    begin
                        state_next = ST_CLIP;
                    end
                    else
                    begin
                        res_next   = trunc_val;
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_CLIP:
            begin
                // An inverted window maps from its upper end downward.
                lo_next  = win_lo;
                inc_next = (win_lo < win_hi);
                den_next = (win_lo < win_hi) ? (win_hi - win_lo) : (win_lo - win_hi);
                if (x_reg < clip_lo)
                begin
                    x_next = clip_lo;
                end
                else if (x_reg > clip_hi)
                begin
                    x_next = clip_hi;
                end
                if (win_lo == win_hi)
                begin
                    res_next   = '0;
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end

            ST_DIFF:
            begin
                num_next   = inc_reg ? (x_reg - lo_reg) : (lo_reg - x_reg);
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                div_req.start = 1'b1;
                use_div_next  = 1'b1;
                state_next    = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                if (!ovalid_reg || !dst_stall)
                begin
                    ovalid_next          = 1'b1;
                    odata_next.pixel_out = use_div_reg ? quotient : res_reg;
                    odata_next.last_out  = last_reg;
                    if (last_reg)
                    begin
                        tmin_next = TrackMinReset;
                        tmax_next = TrackMaxReset;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            tmin_reg   <= TrackMinReset;
            tmax_reg   <= TrackMaxReset;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            tmin_reg   <= tmin_next;
            tmax_reg   <= tmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        lo_reg      <= lo_next;
        last_reg    <= last_next;
        inc_reg     <= inc_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        res_reg     <= res_next;
        use_div_reg <= use_div_next;
        odata_reg   <= odata_next;
    end

    pwr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

endmodule
